FILE: hw/rtl/nnis_pkg.sv
// Shared constants for the nearest-neighbor image scaler.
package nnis_pkg;

   localparam int MAX_SIDE         = 256;
   localparam int MAX_CHANNELS     = 4;
   localparam int STORE_PIXELS_DEF = 65536;

   localparam int NUM_CH  = 4;
   localparam int BYTE_W  = 8;
   localparam int PIX_W   = NUM_CH * BYTE_W;
   localparam int COORD_W = 8;
   localparam int LADDR_W = 16;
   localparam int CFG_W   = 9;
   localparam int CH_W    = 3;

   localparam int DVD_W   = COORD_W + CFG_W;
   localparam int QUO_W   = CFG_W;
   localparam int STEP_W  = $clog2(QUO_W);
   localparam int PROD_W  = 2 * CFG_W;
   localparam int IDX_W   = PROD_W + 1;

   localparam int CSR_DATA_W = 32;
   localparam int PADDR_W    = 5;
   localparam int REG_IDX_W  = PADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CHANNELS   = 3'd4;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef logic [BYTE_W-1:0] byte_type;

endpackage

FILE: hw/rtl/nnis_if.sv
// Request and response channel interfaces of the image scaler.
interface nnis_req_if
   import nnis_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [LADDR_W-1:0]   load_addr;
   byte_type             load_ch0;
   byte_type             load_ch1;
   byte_type             load_ch2;
   byte_type             load_ch3;
   logic [COORD_W-1:0]   dst_x;
   logic [COORD_W-1:0]   dst_y;

   modport source (
      output valid, req_type, load_addr, load_ch0, load_ch1, load_ch2, load_ch3, dst_x, dst_y,
      input  ready
   );
   modport sink (
      input  valid, req_type, load_addr, load_ch0, load_ch1, load_ch2, load_ch3, dst_x, dst_y,
      output ready
   );
endinterface

interface nnis_rsp_if
   import nnis_pkg::*;
;
   logic       valid;
   logic       ready;
   byte_type   out_ch0;
   byte_type   out_ch1;
   byte_type   out_ch2;
   byte_type   out_ch3;
   logic       range_error;

   modport source (
      output valid, out_ch0, out_ch1, out_ch2, out_ch3, range_error,
      input  ready
   );
   modport sink (
      input  valid, out_ch0, out_ch1, out_ch2, out_ch3, range_error,
      output ready
   );
endinterface

FILE: hw/rtl/nnis_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module nnis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/nnis_div.sv
// Restoring divider, one quotient bit per cycle, quotient known to fit QUO_W bits.
module nnis_div
   import nnis_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [QUO_W-1:0] divisor,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [QUO_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [QUO_W-1:0]  low_ff, low_in;
   logic [QUO_W-1:0]  dsr_ff, dsr_in;
   logic [QUO_W:0]    trial;
   logic [QUO_W:0]    diff;
   logic              fit;

   always_comb begin
      trial   = {rem_ff, low_ff[QUO_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      fit     = (trial >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      low_in  = low_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = QUO_W'(dividend[DVD_W-1:QUO_W]);
         low_in  = dividend[QUO_W-1:0];
         dsr_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fit ? diff[QUO_W-1:0] : trial[QUO_W-1:0];
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         quo_in = {quo_ff[QUO_W-2:0], fit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      low_ff <= low_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hw/rtl/nearest_neighbor_image_scaler.sv
// Nearest-neighbor image scaler: source pixels are loaded into an on-chip pixel
// store, then read back by destination coordinate. A read is started, then runs
// the two parallel bit-serial divisions (source x and y), the row-index multiply,
// the pixel store read and a step to register the result. A read that fails the
// range checks skips those steps and goes straight to registering its error
// result. A new item is accepted once the previous read has placed its result in
// the output register, even if that result has not yet been taken.
module nearest_neighbor_image_scaler
   import nnis_pkg::*;
#(
   parameter int STORE_PIXELS = STORE_PIXELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   nnis_req_if.sink              req_if,
   nnis_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [PADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = $clog2(STORE_PIXELS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_IDX  = 3'd2;
   localparam logic [2:0] ST_RD   = 3'd3;
   localparam logic [2:0] ST_DATA = 3'd4;

   logic [CFG_W-1:0]     src_width_ff, src_width_in;
   logic [CFG_W-1:0]     src_height_ff, src_height_in;
   logic [CFG_W-1:0]     dst_width_ff, dst_width_in;
   logic [CFG_W-1:0]     dst_height_ff, dst_height_in;
   logic [CH_W-1:0]      channel_count_ff, channel_count_in;

   logic [2:0]           state_ff, state_in;
   logic                 err_ff, err_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   byte_type             out_ch_ff [NUM_CH];
   byte_type             out_ch_in [NUM_CH];
   logic                 range_error_ff, range_error_in;

   logic                 cfg_wr;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 accept;
   logic                 rd_acc;
   logic                 ram_we;
   logic                 ram_re;
   logic [PIX_W-1:0]     ram_wdata;
   logic [PIX_W-1:0]     ram_rdata;
   logic [PROD_W-1:0]    size_prod;
   logic [PROD_W-1:0]    row_base;
   logic                 sizes_bad;
   logic                 coord_bad;
   logic                 div_start;
   logic [DVD_W-1:0]     prod_x;
   logic [DVD_W-1:0]     prod_y;
   logic                 done_x, done_y;
   logic [QUO_W-1:0]     sx_q, sy_q;
   logic [CH_W-1:0]      nch;

   // configuration registers
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[PADDR_W-1:2];
   assign csr_pready = 1'b1;

   always_comb begin
      src_width_in     = src_width_ff;
      src_height_in    = src_height_ff;
      dst_width_in     = dst_width_ff;
      dst_height_in    = dst_height_ff;
      channel_count_in = channel_count_ff;
      if (cfg_wr) begin
         case (reg_idx)
            REG_SRC_WIDTH:  src_width_in     = csr_pwdata[CFG_W-1:0];
            REG_SRC_HEIGHT: src_height_in    = csr_pwdata[CFG_W-1:0];
            REG_DST_WIDTH:  dst_width_in     = csr_pwdata[CFG_W-1:0];
            REG_DST_HEIGHT: dst_height_in    = csr_pwdata[CFG_W-1:0];
            REG_CHANNELS:   channel_count_in = csr_pwdata[CH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SRC_WIDTH:  csr_prdata = CSR_DATA_W'(src_width_ff);
         REG_SRC_HEIGHT: csr_prdata = CSR_DATA_W'(src_height_ff);
         REG_DST_WIDTH:  csr_prdata = CSR_DATA_W'(dst_width_ff);
         REG_DST_HEIGHT: csr_prdata = CSR_DATA_W'(dst_height_ff);
         REG_CHANNELS:   csr_prdata = CSR_DATA_W'(channel_count_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // request side
   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign rd_acc       = accept && (req_if.req_type == REQ_READ);
   assign ram_we       = accept && (req_if.req_type == REQ_LOAD) &&
                         (32'(req_if.load_addr) < 32'(STORE_PIXELS));
   assign ram_wdata    = {req_if.load_ch3, req_if.load_ch2, req_if.load_ch1, req_if.load_ch0};

   assign size_prod = PROD_W'(src_width_ff) * PROD_W'(src_height_ff);
   assign sizes_bad = (src_width_ff == '0) || (src_height_ff == '0) ||
                      (32'(src_width_ff) > 32'(MAX_SIDE)) ||
                      (32'(src_height_ff) > 32'(MAX_SIDE)) ||
                      (32'(dst_width_ff) > 32'(MAX_SIDE)) ||
                      (32'(dst_height_ff) > 32'(MAX_SIDE)) ||
                      (32'(size_prod) > 32'(STORE_PIXELS));
   assign coord_bad = (CFG_W'(req_if.dst_x) >= dst_width_ff) ||
                      (CFG_W'(req_if.dst_y) >= dst_height_ff);

   assign div_start = rd_acc && !sizes_bad && !coord_bad;
   assign prod_x    = DVD_W'(req_if.dst_x) * DVD_W'(src_width_ff);
   assign prod_y    = DVD_W'(req_if.dst_y) * DVD_W'(src_height_ff);

   nnis_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_x),
      .divisor  (dst_width_ff),
      .done     (done_x),
      .quotient (sx_q)
   );

   nnis_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_y),
      .divisor  (dst_height_ff),
      .done     (done_y),
      .quotient (sy_q)
   );

   assign row_base = PROD_W'(sy_q) * PROD_W'(src_width_ff);
   assign ram_re   = (state_ff == ST_RD);

   nnis_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_PIXELS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (AW'(req_if.load_addr)),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (AW'(idx_ff)),
      .rdata (ram_rdata)
   );

   assign nch = (32'(channel_count_ff) > 32'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) :
                channel_count_ff;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      err_in         = err_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      range_error_in = range_error_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         out_ch_in[c] = out_ch_ff[c];
      end
      case (state_ff)
         ST_IDLE: begin
            if (rd_acc) begin
               if (sizes_bad || coord_bad) begin
                  err_in   = 1'b1;
                  state_in = ST_DATA;
               end else begin
                  err_in   = 1'b0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (done_x) begin
               state_in = ST_IDX;
            end
         end
         ST_IDX: begin
            idx_in   = IDX_W'(row_base) + IDX_W'(sx_q);
            state_in = ST_RD;
         end
         ST_RD: begin
            if (32'(idx_ff) >= 32'(STORE_PIXELS)) begin
               err_in = 1'b1;
            end
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               range_error_in = err_ff;
               for (int c = 0; c < NUM_CH; c++) begin
                  out_ch_in[c] = (!err_ff && (CH_W'(c) < nch)) ?
                                 ram_rdata[c*BYTE_W +: BYTE_W] : '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff     <= CFG_W'(1);
         src_height_ff    <= CFG_W'(1);
         dst_width_ff     <= CFG_W'(1);
         dst_height_ff    <= CFG_W'(1);
         channel_count_ff <= CH_W'(4);
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         src_width_ff     <= src_width_in;
         src_height_ff    <= src_height_in;
         dst_width_ff     <= dst_width_in;
         dst_height_ff    <= dst_height_in;
         channel_count_ff <= channel_count_in;
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff         <= err_in;
      idx_ff         <= idx_in;
      range_error_ff <= range_error_in;
      for (int c = 0; c < NUM_CH; c++) begin
         out_ch_ff[c] <= out_ch_in[c];
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.out_ch0     = out_ch_ff[0];
   assign rsp_if.out_ch1     = out_ch_ff[1];
   assign rsp_if.out_ch2     = out_ch_ff[2];
   assign rsp_if.out_ch3     = out_ch_ff[3];
   assign rsp_if.range_error = range_error_ff;

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      done_x == done_y)
      else $error("x and y dividers out of step");

   a_src_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDX) |-> (sx_q < src_width_ff) && (sy_q < src_height_ff))
      else $error("source coordinate outside source image");

   a_rsp_from_data: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DATA))
      else $error("response raised outside result state");

   a_data_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DATA && !err_ff) |-> $past(state_ff == ST_RD || state_ff == ST_DATA))
      else $error("pixel used without a store read");

endmodule
